@@ hw/rtl/hpsr_pkg.sv @@
// ---------------------------------------------------------------------------
// Serial request engine package
// Shared codes, protocol bytes, result list types and list helpers.
// ---------------------------------------------------------------------------
package hpsr_pkg;

  // Exchange phase
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_ACK  = 2'd1,
    PH_DATA = 2'd2,
    PH_RESP = 2'd3
  } phase_t;

  // Input commands
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_BYTE  = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_TX     = 2'd0;
  localparam logic [1:0] KIND_RESP   = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // Request status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_BAD_ACK = 3'd1;
  localparam logic [2:0] ST_TIMEOUT = 3'd2;
  localparam logic [2:0] ST_BAD_FRM = 3'd3;
  localparam logic [2:0] ST_BAD_KEY = 3'd4;

  // Configuration register indexes
  localparam logic REG_TIMEOUT = 1'b0;
  localparam logic REG_RETRY   = 1'b1;

  // Protocol bytes
  localparam logic [7:0] B_SOH  = 8'h01;
  localparam logic [7:0] B_STX  = 8'h02;
  localparam logic [7:0] B_ETX  = 8'h03;
  localparam logic [7:0] B_DLE  = 8'h10;
  localparam logic [7:0] B_FILL = 8'h18;
  localparam logic [7:0] B_ESC  = 8'h2B;
  localparam logic [7:0] B_ZERO = 8'h00;
  localparam logic [7:0] B_ALT  = 8'h80;

  localparam int unsigned MAX_RES = 8;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [2:0] status;
  } result_t;

  // Results caused by one input beat
  typedef struct packed {
    logic [3:0]                 cnt;
    result_t [MAX_RES-1:0]      ent;
  } list_t;

  // Append one result, dropping anything past the list depth
  function automatic list_t put(list_t l, logic [1:0] kind, logic [7:0] data,
                                logic [2:0] status);
    list_t r;
    r = l;
    if (l.cnt < 4'(MAX_RES)) begin
      r.ent[l.cnt[2:0]].kind   = kind;
      r.ent[l.cnt[2:0]].data   = data;
      r.ent[l.cnt[2:0]].status = status;
      r.cnt = l.cnt + 4'd1;
    end
    return r;
  endfunction

  // Append a transmit byte with its stuffing byte when needed
  function automatic list_t put_stuffed(list_t l, logic [7:0] b);
    list_t r;
    r = put(l, KIND_TX, b, ST_OK);
    if (b == B_DLE) begin
      r = put(r, KIND_TX, B_DLE, ST_OK);
    end else if (b == B_ESC) begin
      r = put(r, KIND_TX, B_FILL, ST_OK);
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/hpsr_engine.sv @@
// ---------------------------------------------------------------------------
// Request engine core
// Exchange state registers and the single-pass step logic that turns one
// accepted input beat into a list of results.
// ---------------------------------------------------------------------------
module hpsr_engine #(
  parameter int MAX_FRAME = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  logic [1:0]      command,
  input  logic [7:0]      request_code,
  input  logic [7:0]      rx_byte,
  input  logic [15:0]     timeout_ticks,
  input  logic [7:0]      retry_limit,
  output hpsr_pkg::list_t list
);

  localparam int CW = $clog2(MAX_FRAME + 2);
  localparam logic [CW-1:0] SAT   = CW'(MAX_FRAME + 1);
  localparam logic [CW-1:0] LIMIT = CW'(MAX_FRAME);

  typedef struct packed {
    logic [CW-1:0]   cnt;
    logic [3:0][7:0] hdr;
    logic [7:0]      sum;
  } body_t;

  // Pass one unstuffed body byte into header capture and checksum
  function automatic body_t emit(body_t s, logic [7:0] b);
    body_t r;
    r = s;
    if (s.cnt < CW'(4)) begin
      r.hdr[s.cnt[1:0]] = b;
    end
    if (s.cnt != CW'(2)) begin
      r.sum = s.sum + b;
    end
    if (s.cnt < SAT) begin
      r.cnt = s.cnt + CW'(1);
    end
    return r;
  endfunction

  hpsr_pkg::phase_t phase, phase_next;
  logic [7:0]    attempt, attempt_next;
  logic [15:0]   elapsed, elapsed_next;
  logic [7:0]    key, key_next;
  logic [7:0]    prior, prior_next;
  logic          held_valid, held_valid_next;
  logic [7:0]    held, held_next;
  logic [CW-1:0] raw_len, raw_len_next;
  logic [CW-1:0] ucount;
  logic [3:0][7:0] hdr;
  logic [7:0]    sum;
  body_t         body_next;
  logic [CW-1:0] raw_inc;
  logic [15:0]   tick_inc;
  logic          bad;

  // Step logic
  always_comb begin
    phase_next      = phase;
    attempt_next    = attempt;
    elapsed_next    = elapsed;
    key_next        = key;
    prior_next      = prior;
    held_valid_next = held_valid;
    held_next       = held;
    raw_len_next    = raw_len;
    body_next.cnt   = ucount;
    body_next.hdr   = hdr;
    body_next.sum   = sum;
    list            = '0;
    raw_inc         = (raw_len < SAT) ? raw_len + CW'(1) : raw_len;
    tick_inc        = (elapsed != 16'hFFFF) ? elapsed + 16'd1 : elapsed;
    bad             = 1'b0;
    if (accept) begin
      case (command)
        hpsr_pkg::CMD_START: begin
          if (phase == hpsr_pkg::PH_IDLE) begin
            key_next        = request_code;
            attempt_next    = 8'd1;
            prior_next      = '0;
            held_valid_next = 1'b0;
            held_next       = '0;
            list = hpsr_pkg::put(list, hpsr_pkg::KIND_TX, hpsr_pkg::B_STX, hpsr_pkg::ST_OK);
            phase_next      = hpsr_pkg::PH_ACK;
            elapsed_next    = '0;
          end
        end
        hpsr_pkg::CMD_BYTE: begin
          case (phase)
            hpsr_pkg::PH_ACK: begin
              if (rx_byte != hpsr_pkg::B_DLE) begin
                list = hpsr_pkg::put(list, hpsr_pkg::KIND_STATUS, 8'h00,
                                     hpsr_pkg::ST_BAD_ACK);
                phase_next      = hpsr_pkg::PH_IDLE;
                prior_next      = '0;
                held_valid_next = 1'b0;
              end else begin
                // send the request frame
                list = hpsr_pkg::put(list, hpsr_pkg::KIND_TX, hpsr_pkg::B_SOH, hpsr_pkg::ST_OK);
                list = hpsr_pkg::put(list, hpsr_pkg::KIND_TX, hpsr_pkg::B_ZERO, hpsr_pkg::ST_OK);
                list = hpsr_pkg::put_stuffed(list, hpsr_pkg::B_SOH + key);
                list = hpsr_pkg::put_stuffed(list, key);
                list = hpsr_pkg::put(list, hpsr_pkg::KIND_TX, hpsr_pkg::B_DLE, hpsr_pkg::ST_OK);
                list = hpsr_pkg::put(list, hpsr_pkg::KIND_TX, hpsr_pkg::B_ETX, hpsr_pkg::ST_OK);
                phase_next   = hpsr_pkg::PH_DATA;
                elapsed_next = '0;
                prior_next   = '0;
              end
            end
            hpsr_pkg::PH_DATA: begin
              if (prior == hpsr_pkg::B_DLE && rx_byte == hpsr_pkg::B_STX) begin
                list = hpsr_pkg::put(list, hpsr_pkg::KIND_TX, hpsr_pkg::B_DLE, hpsr_pkg::ST_OK);
                phase_next      = hpsr_pkg::PH_RESP;
                elapsed_next    = '0;
                prior_next      = '0;
                held_valid_next = 1'b0;
                held_next       = '0;
                raw_len_next    = '0;
                body_next.cnt   = '0;
                body_next.sum   = '0;
              end else begin
                prior_next = rx_byte;
              end
            end
            hpsr_pkg::PH_RESP: begin
              raw_len_next = raw_inc;
              if (raw_inc > CW'(4) && prior == hpsr_pkg::B_DLE &&
                  rx_byte == hpsr_pkg::B_ETX) begin
                // tail reached: pass it out and judge the frame
                held_valid_next = 1'b0;
                list = hpsr_pkg::put(list, hpsr_pkg::KIND_RESP, hpsr_pkg::B_DLE, hpsr_pkg::ST_OK);
                list = hpsr_pkg::put(list, hpsr_pkg::KIND_RESP, hpsr_pkg::B_ETX, hpsr_pkg::ST_OK);
                bad = (raw_inc > LIMIT) || (ucount < CW'(3)) ||
                      (hdr[0] != hpsr_pkg::B_SOH) ||
                      (hdr[1] != hpsr_pkg::B_ZERO && hdr[1] != hpsr_pkg::B_ALT) ||
                      (sum != hdr[2]);
                if (bad) begin
                  list = hpsr_pkg::put(list, hpsr_pkg::KIND_STATUS, 8'h00,
                                       hpsr_pkg::ST_BAD_FRM);
                end else if (hdr[3] != key) begin
                  list = hpsr_pkg::put(list, hpsr_pkg::KIND_STATUS, 8'h00,
                                       hpsr_pkg::ST_BAD_KEY);
                end else begin
                  list = hpsr_pkg::put(list, hpsr_pkg::KIND_STATUS, 8'h00, hpsr_pkg::ST_OK);
                end
                phase_next = hpsr_pkg::PH_IDLE;
                prior_next = '0;
              end else begin
                // unstuff the body
                if (held_valid &&
                    ((held == hpsr_pkg::B_DLE && rx_byte == hpsr_pkg::B_DLE) ||
                     (held == hpsr_pkg::B_ESC && rx_byte == hpsr_pkg::B_FILL))) begin
                  body_next = emit(body_next, held);
                  list = hpsr_pkg::put(list, hpsr_pkg::KIND_RESP, held, hpsr_pkg::ST_OK);
                  held_valid_next = 1'b0;
                end else begin
                  if (held_valid) begin
                    body_next = emit(body_next, held);
                    list = hpsr_pkg::put(list, hpsr_pkg::KIND_RESP, held, hpsr_pkg::ST_OK);
                    held_valid_next = 1'b0;
                  end
                  if (rx_byte == hpsr_pkg::B_DLE || rx_byte == hpsr_pkg::B_ESC) begin
                    held_next       = rx_byte;
                    held_valid_next = 1'b1;
                  end else begin
                    body_next = emit(body_next, rx_byte);
                    list = hpsr_pkg::put(list, hpsr_pkg::KIND_RESP, rx_byte, hpsr_pkg::ST_OK);
                  end
                end
                prior_next = rx_byte;
              end
            end
            default: begin
            end
          endcase
        end
        hpsr_pkg::CMD_TICK: begin
          if (phase != hpsr_pkg::PH_IDLE) begin
            elapsed_next = tick_inc;
            if (tick_inc >= timeout_ticks) begin
              if (phase == hpsr_pkg::PH_ACK && attempt < retry_limit) begin
                // resend the start byte
                attempt_next    = (attempt != 8'hFF) ? attempt + 8'd1 : attempt;
                prior_next      = '0;
                held_valid_next = 1'b0;
                held_next       = '0;
                list = hpsr_pkg::put(list, hpsr_pkg::KIND_TX, hpsr_pkg::B_STX, hpsr_pkg::ST_OK);
                phase_next      = hpsr_pkg::PH_ACK;
                elapsed_next    = '0;
              end else begin
                list = hpsr_pkg::put(list, hpsr_pkg::KIND_STATUS, 8'h00,
                                     hpsr_pkg::ST_TIMEOUT);
                phase_next      = hpsr_pkg::PH_IDLE;
                prior_next      = '0;
                held_valid_next = 1'b0;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= hpsr_pkg::PH_IDLE;
      attempt    <= '0;
      elapsed    <= '0;
      key        <= '0;
      prior      <= '0;
      held_valid <= 1'b0;
      held       <= '0;
      raw_len    <= '0;
      ucount     <= '0;
      sum        <= '0;
    end else begin
      phase      <= phase_next;
      attempt    <= attempt_next;
      elapsed    <= elapsed_next;
      key        <= key_next;
      prior      <= prior_next;
      held_valid <= held_valid_next;
      held       <= held_next;
      raw_len    <= raw_len_next;
      ucount     <= body_next.cnt;
      sum        <= body_next.sum;
    end
  end

  // Header capture, written only by body bytes
  always_ff @(posedge clk) begin
    hdr <= body_next.hdr;
  end

  // A held byte only exists while collecting a response
  a_held_in_resp: assert property (@(posedge clk) disable iff (rst)
    held_valid |-> phase == hpsr_pkg::PH_RESP)
    else $error("held byte outside response phase");

  // A start while idle always opens the acknowledgment wait
  a_start_opens: assert property (@(posedge clk) disable iff (rst)
    accept && command == hpsr_pkg::CMD_START && phase == hpsr_pkg::PH_IDLE
    |=> phase == hpsr_pkg::PH_ACK && attempt == 8'd1)
    else $error("start did not open acknowledgment wait");

  // Leaving for idle always reports a status as the final result
  a_idle_status: assert property (@(posedge clk) disable iff (rst)
    phase != hpsr_pkg::PH_IDLE && phase_next == hpsr_pkg::PH_IDLE
    |-> list.cnt != 4'd0 && list.ent[list.cnt[2:0] - 3'd1].kind == hpsr_pkg::KIND_STATUS)
    else $error("return to idle without status");

endmodule

@@ hw/rtl/hpsr_resq.sv @@
// ---------------------------------------------------------------------------
// Result queue
// Two result-list slots: one drains one result per beat while the other
// takes the list of the next input beat.
// ---------------------------------------------------------------------------
module hpsr_resq (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  hpsr_pkg::list_t  list,
  output logic             free,
  output logic             out_valid,
  input  logic             out_ready,
  output hpsr_pkg::result_t entry,
  output logic             last
);

  hpsr_pkg::list_t slot [2];
  logic [1:0] full;
  logic       wr_sel;
  logic       rd_sel;
  logic [2:0] rd_idx;
  logic       pop;

  // Present the current result
  always_comb begin
    free      = !full[wr_sel];
    out_valid = full[rd_sel];
    entry     = slot[rd_sel].ent[rd_idx];
    last      = ({1'b0, rd_idx} == slot[rd_sel].cnt - 4'd1);
    pop       = out_valid && out_ready;
  end

  // Slot payload
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_sel] <= list;
    end
  end

  // Fill and drain control
  always_ff @(posedge clk) begin
    if (rst) begin
      full   <= '0;
      wr_sel <= 1'b0;
      rd_sel <= 1'b0;
      rd_idx <= '0;
    end else begin
      if (pop) begin
        if (last) begin
          full[rd_sel] <= 1'b0;
          rd_sel       <= !rd_sel;
          rd_idx       <= '0;
        end else begin
          rd_idx <= rd_idx + 3'd1;
        end
      end
      if (push) begin
        full[wr_sel] <= 1'b1;
        wr_sel       <= !wr_sel;
      end
    end
  end

  // A full slot never holds an empty list
  a_slot_nonempty: assert property (@(posedge clk) disable iff (rst)
    full[rd_sel] |-> slot[rd_sel].cnt != 4'd0)
    else $error("empty list in full slot");

  // Slots drain in fill order: an empty read slot means the queue is empty
  a_order: assert property (@(posedge clk) disable iff (rst)
    !full[rd_sel] |-> full == 2'b00 && rd_idx == 3'd0)
    else $error("slot order broken");

endmodule

@@ hw/rtl/heat_pump_serial_request_engine.sv @@
// Results: those of an accepted input beat are registered into a result-list
// slot and leave one per cycle while out_ready is high.
// Throughput: one input beat per cycle while each causes at most one result
// and out_ready is high; input is taken while one of the two list slots is free.
// Reset: synchronous, active high; returns to idle with an empty queue,
// timeout_ticks 100 and retry_limit 3.
// ---------------------------------------------------------------------------
// Heat pump serial request engine
// Master side of one stuffed serial request exchange with retries, timeout
// and response unstuffing and checking.
// ---------------------------------------------------------------------------
module heat_pump_serial_request_engine #(
  parameter int MAX_FRAME = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic [7:0]  request_code,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  result_kind,
  output logic [7:0]  data_byte,
  output logic [2:0]  status,
  output logic        last,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  logic [15:0] timeout_ticks;
  logic [7:0]  retry_limit;
  logic        accept;
  hpsr_pkg::list_t   list;
  hpsr_pkg::result_t entry;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= 16'd100;
      retry_limit   <= 8'd3;
    end else if (cfg_write) begin
      case (cfg_index)
        hpsr_pkg::REG_TIMEOUT: timeout_ticks <= cfg_data;
        hpsr_pkg::REG_RETRY:   retry_limit   <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  assign accept = in_valid && in_ready;

  hpsr_engine #(
    .MAX_FRAME (MAX_FRAME)
  ) u_engine (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .command       (command),
    .request_code  (request_code),
    .rx_byte       (rx_byte),
    .timeout_ticks (timeout_ticks),
    .retry_limit   (retry_limit),
    .list          (list)
  );

  hpsr_resq u_resq (
    .clk       (clk),
    .rst       (rst),
    .push      (accept && list.cnt != 4'd0),
    .list      (list),
    .free      (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .entry     (entry),
    .last      (last)
  );

  // Drive the result fields
  assign result_kind = entry.kind;
  assign data_byte   = entry.data;
  assign status      = entry.status;

endmodule
